// ----- hdl/swnd_pkg.sv -----
// ============================================================================
// swnd_pkg
// Shared types, constants and helpers for the sliding window sender.
// ============================================================================
package swnd_pkg;

    // Build-time window depth (1..64) and per-command send limit
    localparam int WINDOW_DEPTH = 32;
    localparam int MAX_RESULTS  = 32;

    localparam int SEQ_W   = 32;
    localparam int SIZE_W  = 6;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Slot index, window count and send count widths
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int NRES_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // Command queue between front and engine (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SEQ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

    localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 6'd32;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Classified command carried through the queue
    typedef enum logic [1:0] {
        OP_START,
        OP_ACK,
        OP_TIMEOUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SEQ_W-1:0] ack;
    } item_t;

    // Engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_APPLY,
        ST_PREP,
        ST_SCAN
    } eng_state_t;

    // Effective window: zero acts as one, clipped to the built depth
    function automatic logic [WCNT_W-1:0] eff_window(input logic [SIZE_W-1:0] size);
        logic [WCNT_W-1:0] r;
        if (size == '0) begin
            r = WCNT_W'(1);
        end else if (32'(size) > WINDOW_DEPTH) begin
            r = WCNT_W'(WINDOW_DEPTH);
        end else begin
            r = WCNT_W'(size);
        end
        return r;
    endfunction

endpackage

// ----- hdl/sliding_window_sender_top.sv -----
// ============================================================================
// sliding_window_sender_top
// Cumulative-acknowledgement sliding window sender.
// ============================================================================
// Commands (start, acknowledgement, timeout) enter through the s_ channel and
// are decoded into a two-entry queue, so the input can take up to three beats
// ahead of the engine. The engine handles one command at a time: it fetches,
// classifies and applies it, then collects the slots to send, then emits one
// send beat per cycle while the result register is free (m_ready high or no
// beat held). A completion beat is presented from the apply step.
// Sent flags live in flip-flops, so no clearing pass follows reset.
// Configuration writes are taken every cycle and must only be issued while no
// command is in flight.
// ============================================================================
module sliding_window_sender_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [swnd_pkg::CMD_W-1:0]      s_command,
    input  logic [swnd_pkg::SEQ_W-1:0]      s_ack_number,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swnd_pkg::CFG_DATA_W-1:0] cfg_data,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [swnd_pkg::SEQ_W-1:0]      m_packet_sequence,
    output logic                            m_last_of_run
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    swnd_pkg::item_t push_item;
    swnd_pkg::item_t pop_item;

    swnd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_ack_number (s_ack_number),
        .q_push       (q_push),
        .q_item       (push_item),
        .q_full       (q_full)
    );

    swnd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    swnd_engine u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_empty           (q_empty),
        .q_item            (pop_item),
        .q_pop             (q_pop),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_packet_sequence (m_packet_sequence),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

// ----- hdl/swnd_front.sv -----
// ============================================================================
// swnd_front
// Input side: takes command beats, decodes them and holds one for the queue.
// ============================================================================
module swnd_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [swnd_pkg::CMD_W-1:0] s_command,
    input  logic [swnd_pkg::SEQ_W-1:0] s_ack_number,
    output logic                       q_push,
    output swnd_pkg::item_t            q_item,
    input  logic                       q_full
);

    logic            hold_valid_reg, hold_valid_next;
    swnd_pkg::item_t hold_item_reg, hold_item_next;
    logic            cmd_known;
    swnd_pkg::op_t   op_dec;

    // Command decode; the reserved code is dropped here
    always_comb begin
        cmd_known = 1'b1;
        op_dec    = swnd_pkg::OP_START;
        case (s_command)
            swnd_pkg::CMD_START:   op_dec = swnd_pkg::OP_START;
            swnd_pkg::CMD_ACK:     op_dec = swnd_pkg::OP_ACK;
            swnd_pkg::CMD_TIMEOUT: op_dec = swnd_pkg::OP_TIMEOUT;
            default:               cmd_known = 1'b0;
        endcase
    end

    assign q_push  = hold_valid_reg && !q_full;
    assign q_item  = hold_item_reg;
    assign s_ready = !hold_valid_reg || !q_full;

    // Holding stage
    always_comb begin
        hold_valid_next = hold_valid_reg && !q_push;
        hold_item_next  = hold_item_reg;
        if (s_valid && s_ready) begin
            hold_valid_next    = cmd_known;
            hold_item_next.op  = op_dec;
            hold_item_next.ack = s_ack_number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_item_reg <= hold_item_next;
    end

endmodule

// ----- hdl/swnd_queue.sv -----
// ============================================================================
// swnd_queue
// Short FIFO of decoded commands between the front and the engine.
// ============================================================================
module swnd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  swnd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output swnd_pkg::item_t pop_item,
    output logic            empty
);

    swnd_pkg::item_t                  mem_reg [swnd_pkg::QUEUE_DEPTH];
    logic [swnd_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [swnd_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [swnd_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign full     = (count_reg == swnd_pkg::QCNT_W'(swnd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update; pointers wrap naturally
    always_comb begin
        wr_ptr_next = wr_ptr_reg + swnd_pkg::QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + swnd_pkg::QPTR_W'(do_pop);
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/swnd_engine.sv -----
// ============================================================================
// swnd_engine
// Window state, configuration and send sequencer with the result register.
// ============================================================================
module swnd_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command queue
    input  logic                            q_empty,
    input  swnd_pkg::item_t                 q_item,
    output logic                            q_pop,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swnd_pkg::CFG_DATA_W-1:0] cfg_data,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [swnd_pkg::SEQ_W-1:0]      m_packet_sequence,
    output logic                            m_last_of_run
);

    localparam int D = swnd_pkg::WINDOW_DEPTH;

    swnd_pkg::eng_state_t             state_reg, state_next;
    swnd_pkg::op_t                    cur_op_reg, cur_op_next;
    logic [swnd_pkg::SEQ_W-1:0]       ack_reg, ack_next;
    logic [swnd_pkg::SEQ_W-1:0]       base_reg, base_next;
    logic                             active_reg, active_next;
    logic [D-1:0]                     sent_reg, sent_next;
    logic                             gt_last_reg, gt_last_next;
    logic                             in_win_reg, in_win_next;
    logic [swnd_pkg::SLOT_W-1:0]      k_reg, k_next;
    logic [D-1:0]                     pend_reg, pend_next;
    logic [swnd_pkg::NRES_W-1:0]      n_reg, n_next;
    logic [swnd_pkg::SEQ_W-1:0]       first_reg, first_next;
    logic [swnd_pkg::SEQ_W-1:0]       last_reg, last_next;
    logic [swnd_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             m_kind_reg, m_kind_next;
    logic [swnd_pkg::SEQ_W-1:0]       m_seq_reg, m_seq_next;
    logic                             m_last_reg, m_last_next;

    logic [swnd_pkg::WCNT_W-1:0]      w;
    logic [swnd_pkg::WCNT_W-1:0]      w_new;
    logic                             out_free;
    logic [swnd_pkg::SEQ_W-1:0]       ack_off;
    logic [swnd_pkg::SEQ_W:0]         win_end;
    logic [swnd_pkg::SEQ_W:0]         room;
    logic [D-1:0]                     slid;
    logic [D-1:0]                     mask;
    logic [D-1:0]                     pend_rest;
    logic [swnd_pkg::SLOT_W-1:0]      pick;
    logic                             run_done;
    logic                             complete_now;

    assign w        = swnd_pkg::eff_window(size_reg);
    assign w_new    = swnd_pkg::eff_window(cfg_data[swnd_pkg::SIZE_W-1:0]);
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid           = m_valid_reg;
    assign m_kind            = m_kind_reg;
    assign m_packet_sequence = m_seq_reg;
    assign m_last_of_run     = m_last_reg;

    // Window compares on the latched acknowledgement
    assign ack_off = ack_reg - base_reg;
    assign win_end = {1'b0, base_reg} + (swnd_pkg::SEQ_W + 1)'(w);

    // Slide: shift sent flags down by k, slots entering the window are unsent
    always_comb begin
        slid = sent_reg >> k_reg;
        for (int i = 0; i < D; i++) begin
            if (swnd_pkg::WCNT_W'(i) >= (w - swnd_pkg::WCNT_W'(k_reg)) &&
                swnd_pkg::WCNT_W'(i) < w) begin
                slid[i] = 1'b0;
            end
        end
    end

    // Slots to send: unsent, inside the window, not past the last packet
    assign room = {1'b0, last_reg} - {1'b0, base_reg};
    always_comb begin
        for (int i = 0; i < D; i++) begin
            mask[i] = !sent_reg[i] && (swnd_pkg::WCNT_W'(i) < w) && !room[swnd_pkg::SEQ_W] &&
                      (room[swnd_pkg::SEQ_W-1:0] >= swnd_pkg::SEQ_W'(i));
        end
    end

    // Lowest pending slot
    always_comb begin
        pick = '0;
        for (int i = D - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pick = swnd_pkg::SLOT_W'(i);
            end
        end
    end
    assign pend_rest = pend_reg & (pend_reg - 1'b1);
    assign run_done  = (pend_rest == '0) ||
                       (n_reg == swnd_pkg::NRES_W'(swnd_pkg::MAX_RESULTS - 1));

    assign complete_now = (cur_op_reg == swnd_pkg::OP_ACK) && active_reg && gt_last_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swnd_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    state_next = swnd_pkg::ST_CLASSIFY;
                end
            end
            swnd_pkg::ST_CLASSIFY: begin
                state_next = swnd_pkg::ST_APPLY;
            end
            swnd_pkg::ST_APPLY: begin
                if (cur_op_reg == swnd_pkg::OP_START) begin
                    state_next = swnd_pkg::ST_PREP;
                end else if (!active_reg) begin
                    state_next = swnd_pkg::ST_IDLE;
                end else if (complete_now) begin
                    if (out_free) begin
                        state_next = swnd_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = swnd_pkg::ST_PREP;
                end
            end
            swnd_pkg::ST_PREP: begin
                state_next = (mask != '0) ? swnd_pkg::ST_SCAN : swnd_pkg::ST_IDLE;
            end
            swnd_pkg::ST_SCAN: begin
                if (out_free && run_done) begin
                    state_next = swnd_pkg::ST_IDLE;
                end
            end
            default: state_next = swnd_pkg::ST_IDLE;
        endcase
    end

    // Datapath, window state and result register
    always_comb begin
        q_pop        = 1'b0;
        cur_op_next  = cur_op_reg;
        ack_next     = ack_reg;
        base_next    = base_reg;
        active_next  = active_reg;
        sent_next    = sent_reg;
        gt_last_next = gt_last_reg;
        in_win_next  = in_win_reg;
        k_next       = k_reg;
        pend_next    = pend_reg;
        n_next       = n_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        size_next    = size_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_seq_next   = m_seq_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            swnd_pkg::ST_IDLE: begin
                q_pop       = !q_empty;
                cur_op_next = q_item.op;
                ack_next    = q_item.ack;
            end
            swnd_pkg::ST_CLASSIFY: begin
                gt_last_next = ack_reg > last_reg;
                in_win_next  = (base_reg < ack_reg) && ({1'b0, ack_reg} < win_end);
                k_next       = ack_off[swnd_pkg::SLOT_W-1:0];
            end
            swnd_pkg::ST_APPLY: begin
                n_next = '0;
                if (cur_op_reg == swnd_pkg::OP_START) begin
                    base_next   = first_reg;
                    active_next = 1'b1;
                    sent_next   = '0;
                end else if (active_reg) begin
                    if (complete_now) begin
                        if (out_free) begin
                            active_next  = 1'b0;
                            m_valid_next = 1'b1;
                            m_kind_next  = swnd_pkg::KIND_DONE;
                            m_seq_next   = '0;
                            m_last_next  = 1'b1;
                        end
                    end else if (cur_op_reg == swnd_pkg::OP_ACK && in_win_reg) begin
                        sent_next = slid;
                        base_next = ack_reg;
                    end else begin
                        sent_next[0] = 1'b0;
                    end
                end
            end
            swnd_pkg::ST_PREP: begin
                pend_next = mask;
            end
            swnd_pkg::ST_SCAN: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = swnd_pkg::KIND_SEND;
                    m_seq_next      = base_reg + swnd_pkg::SEQ_W'(pick);
                    m_last_next     = run_done;
                    sent_next[pick] = 1'b1;
                    pend_next       = pend_rest;
                    n_next          = n_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Configuration writes; shrinking the window clears slots outside it
        if (cfg_valid) begin
            case (cfg_index)
                swnd_pkg::REG_FIRST_SEQ: first_next = cfg_data;
                swnd_pkg::REG_LAST_SEQ:  last_next  = cfg_data;
                swnd_pkg::REG_WINDOW_SIZE: begin
                    size_next = cfg_data[swnd_pkg::SIZE_W-1:0];
                    for (int i = 0; i < D; i++) begin
                        if (swnd_pkg::WCNT_W'(i) >= w_new) begin
                            sent_next[i] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swnd_pkg::ST_IDLE;
            base_reg    <= '0;
            active_reg  <= 1'b0;
            sent_reg    <= '0;
            n_reg       <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            size_reg    <= swnd_pkg::WINDOW_SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            active_reg  <= active_next;
            sent_reg    <= sent_next;
            n_reg       <= n_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_op_reg  <= cur_op_next;
        ack_reg     <= ack_next;
        gt_last_reg <= gt_last_next;
        in_win_reg  <= in_win_next;
        k_reg       <= k_next;
        pend_reg    <= pend_next;
        m_kind_reg  <= m_kind_next;
        m_seq_reg   <= m_seq_next;
        m_last_reg  <= m_last_next;
    end

`ifndef SYNTHESIS
    // Scan is only entered or kept with slots left to send
    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == swnd_pkg::ST_SCAN |-> pend_reg != '0)
        else $error("scan state with no pending slot");

    // Completion closes the transfer and presents the done beat
    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swnd_pkg::ST_APPLY && complete_now && out_free) |=>
        (!active_reg && m_valid_reg && m_kind_reg == swnd_pkg::KIND_DONE))
        else $error("completion did not end the transfer");

    // Window base only moves when a command is applied
    a_base_moves_in_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(base_reg) |-> $past(state_reg) == swnd_pkg::ST_APPLY)
        else $error("window base changed outside apply");

    // Done beat is always a lone, zero-sequence final beat
    a_done_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == swnd_pkg::KIND_DONE) |->
        (m_last_reg && m_seq_reg == '0))
        else $error("malformed completion beat");
`endif

endmodule

// ----- tb/sv/sliding_window_sender_top_tb.sv -----
// ============================================================================
// sliding_window_sender_top_tb
// Self-checking bench for the sliding window sender.
// ============================================================================
// Commands go in on the s_ channel and configuration on the cfg channel. A
// predictor in this file tracks the window base, the active flag and the
// per-slot sent flags. At each accepted command it queues the send and
// completion beats the block should produce. Every m_ beat is checked, field
// by field, against the oldest queued beat. Directed tests cover the reset
// defaults, window slides, the ends of the sequence space and window resizing.
// Random phases follow, each with its own configuration and mostly
// well-formed acknowledgement traffic. Both sides idle at random, except
// during one phase that runs flat out.
// ============================================================================
module sliding_window_sender_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int IDLE_PCT      = 21;
    localparam int RANDOM_ITEMS  = 170;

    // Codes the package leaves unnamed
    localparam logic [swnd_pkg::CMD_W-1:0]     CMD_RESERVED = 2'd3;
    localparam logic [swnd_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

    typedef struct packed {
        logic                       kind;
        logic [swnd_pkg::SEQ_W-1:0] seq;
        logic                       last;
    } tx_beat_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [swnd_pkg::CMD_W-1:0]      s_command;
    logic [swnd_pkg::SEQ_W-1:0]      s_ack_number;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [swnd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swnd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_kind;
    logic [swnd_pkg::SEQ_W-1:0]      m_packet_sequence;
    logic                            m_last_of_run;

    // Predicted block state and configuration
    logic [swnd_pkg::SEQ_W-1:0]        pred_first_seq;
    logic [swnd_pkg::SEQ_W-1:0]        pred_last_seq;
    logic [swnd_pkg::SIZE_W-1:0]       pred_wsize;
    logic [swnd_pkg::SEQ_W-1:0]        pred_base;
    logic                              pred_active;
    logic [swnd_pkg::WINDOW_DEPTH-1:0] pred_sent;

    tx_beat_t pending_beats[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       no_gaps        = 1'b0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    sliding_window_sender_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_ack_number      (s_ack_number),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_packet_sequence (m_packet_sequence),
        .m_last_of_run     (m_last_of_run)
    );

    // Slots in use: zero acts as one, clipped to the built depth
    function automatic int active_slots();
        int w;
        w = int'(pred_wsize);
        if (w < 1) w = 1;
        if (w > swnd_pkg::WINDOW_DEPTH) w = swnd_pkg::WINDOW_DEPTH;
        return w;
    endfunction

    // Append one expected beat
    function automatic void queue_beat(input tx_beat_t b);
        pending_beats = {pending_beats, b};
    endfunction

    function automatic void apply_reg_write(input logic [swnd_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [swnd_pkg::CFG_DATA_W-1:0] data);
        int w;
        int i;
        case (idx)
            swnd_pkg::REG_FIRST_SEQ: begin
                pred_first_seq = data;
            end
            swnd_pkg::REG_LAST_SEQ: begin
                pred_last_seq = data;
            end
            swnd_pkg::REG_WINDOW_SIZE: begin
                pred_wsize = data[swnd_pkg::SIZE_W-1:0];
                w = active_slots();
                // slots dropped from the window lose their sent flag
                for (i = w; i < swnd_pkg::WINDOW_DEPTH; i++) pred_sent[i] = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    // Apply one command to the predicted state and queue the beats it causes
    function automatic void predict_sends(input logic [swnd_pkg::CMD_W-1:0] cmd,
                                          input logic [swnd_pkg::SEQ_W-1:0] ack);
        int                         w;
        int                         k;
        int                         n;
        int                         i;
        logic [swnd_pkg::SEQ_W:0]   seq;
        bit                         emit_sends;
        bit                         have_held;
        tx_beat_t                   held;
        w = active_slots();
        emit_sends = 1'b1;
        have_held = 1'b0;
        n = 0;
        if (cmd == swnd_pkg::CMD_START) begin
            pred_base = pred_first_seq;
            pred_active = 1'b1;
            pred_sent = '0;
        end else if (cmd == swnd_pkg::CMD_ACK && pred_active) begin
            if (ack > pred_last_seq) begin
                pred_active = 1'b0;
                held = '{swnd_pkg::KIND_DONE, '0, 1'b1};
                queue_beat(held);
                emit_sends = 1'b0;
            end else if (ack > pred_base &&
                         {1'b0, ack} < {1'b0, pred_base} + (swnd_pkg::SEQ_W + 1)'(w)) begin
                // slide: flags move down, new top slots start unsent
                k = int'(ack - pred_base);
                pred_sent = pred_sent >> k;
                for (i = w - k; i < w; i++) pred_sent[i] = 1'b0;
                pred_base = ack;
            end else begin
                pred_sent[0] = 1'b0;
            end
        end else if (cmd == swnd_pkg::CMD_TIMEOUT && pred_active) begin
            pred_sent[0] = 1'b0;
        end else begin
            emit_sends = 1'b0;
        end

        if (emit_sends) begin
            // hold one beat back so the final one can carry last_of_run
            for (i = 0; i < w && n < swnd_pkg::MAX_RESULTS; i++) begin
                seq = {1'b0, pred_base} + (swnd_pkg::SEQ_W + 1)'(i);
                if (!pred_sent[i] && seq <= {1'b0, pred_last_seq}) begin
                    if (have_held) queue_beat(held);
                    held = '{swnd_pkg::KIND_SEND, seq[swnd_pkg::SEQ_W-1:0], 1'b0};
                    have_held = 1'b1;
                    pred_sent[i] = 1'b1;
                    n++;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                queue_beat(held);
            end
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin : check_beat
        tx_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, kind %0d sequence %h last %0d",
                         $time, m_kind, m_packet_sequence, m_last_of_run);
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_kind !== want.kind) begin
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, want.kind, m_kind);
                    mismatch_count++;
                end
                if (m_packet_sequence !== want.seq) begin
                    $display("%0t: packet_sequence mismatch, expected %h, got %h",
                             $time, want.seq, m_packet_sequence);
                    mismatch_count++;
                end
                if (m_last_of_run !== want.last) begin
                    $display("%0t: last_of_run mismatch, expected %0d, got %0d",
                             $time, want.last, m_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One command beat, with a random gap ahead of it
    task automatic send_command(input logic [swnd_pkg::CMD_W-1:0] cmd,
                                input logic [swnd_pkg::SEQ_W-1:0] ack);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_ack_number <= ack;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sends(cmd, ack);
    endtask

    // Drain: every expected beat seen, then time for result-free commands
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register beat; cfg_valid is left high for a following write
    task automatic write_reg(input logic [swnd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swnd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg_write(idx, data);
    endtask

    task automatic write_one(input logic [swnd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swnd_pkg::CFG_DATA_W-1:0] data);
        wait_quiet();
        write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [swnd_pkg::SEQ_W-1:0] first,
                              input logic [swnd_pkg::SEQ_W-1:0] last,
                              input logic [swnd_pkg::CFG_DATA_W-1:0] wdata);
        wait_quiet();
        write_reg(swnd_pkg::REG_FIRST_SEQ, first);
        write_reg(swnd_pkg::REG_LAST_SEQ, last);
        write_reg(swnd_pkg::REG_WINDOW_SIZE, wdata);
        cfg_valid <= 1'b0;
    endtask

    // Reset configuration, idle commands, reserved command, spare register
    task automatic test_reset_defaults();
        send_command(swnd_pkg::CMD_ACK, '0);
        send_command(swnd_pkg::CMD_TIMEOUT, '1);
        send_command(CMD_RESERVED, '1);
        send_command(swnd_pkg::CMD_START, '1);
        send_command(swnd_pkg::CMD_ACK, '0);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
        send_command(swnd_pkg::CMD_ACK, 32'd1);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
        write_one(REG_SPARE, '1);
    endtask

    // Slides, duplicate and stale acks, acks at the window edge, restart
    task automatic test_window_slide();
        set_config(32'd100, 32'd140, 32'd8);
        send_command(swnd_pkg::CMD_START, '0);
        send_command(swnd_pkg::CMD_ACK, 32'd103);
        send_command(swnd_pkg::CMD_ACK, 32'd103);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
        send_command(swnd_pkg::CMD_ACK, 32'd111);
        send_command(swnd_pkg::CMD_ACK, 32'd50);
        send_command(swnd_pkg::CMD_START, '0);
        send_command(swnd_pkg::CMD_ACK, '1);
    endtask

    // Empty transfer, top of sequence space, full window, window of zero
    task automatic test_sequence_limits();
        set_config(32'd500, 32'd499, 32'd4);
        send_command(swnd_pkg::CMD_START, '0);
        set_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd32);
        send_command(swnd_pkg::CMD_START, '0);
        send_command(swnd_pkg::CMD_ACK, 32'hFFFF_FFFF);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
        set_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(swnd_pkg::CMD_START, '0);
        send_command(swnd_pkg::CMD_ACK, 32'd32);
        send_command(swnd_pkg::CMD_ACK, 32'd31);
        write_one(swnd_pkg::REG_WINDOW_SIZE, 32'd0);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
    endtask

    // Shrinking the window mid-transfer clears the dropped slots
    task automatic test_window_resize();
        set_config(32'd1000, 32'd1100, 32'd16);
        send_command(swnd_pkg::CMD_START, '0);
        write_one(swnd_pkg::REG_WINDOW_SIZE, 32'd4);
        write_one(swnd_pkg::REG_WINDOW_SIZE, 32'd16);
        send_command(swnd_pkg::CMD_TIMEOUT, '0);
        send_command(swnd_pkg::CMD_ACK, 32'd1101);
    endtask

    // Random phases: new configuration each, mostly in-window acks
    task automatic test_random_traffic();
        int                              counted;
        int                              phase;
        int                              n;
        int                              j;
        int                              r;
        int                              w;
        logic [swnd_pkg::SEQ_W-1:0]      first;
        logic [swnd_pkg::SEQ_W-1:0]      last;
        logic [swnd_pkg::SEQ_W-1:0]      ack;
        logic [swnd_pkg::CFG_DATA_W-1:0] wdata;
        logic [swnd_pkg::CMD_W-1:0]      cmd;
        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: first = $urandom_range(0, 2000);
                1: first = $urandom();
                default: first = 32'hFFFF_FFFF - $urandom_range(0, 40);
            endcase
            last = first + $urandom_range(0, 80);
            if (last < first) last = '1;
            if ($urandom_range(0, 9) == 0) last = first - 1;
            wdata = $urandom_range(0, 63);
            if ($urandom_range(0, 3) == 0) wdata = ($urandom() & 32'hFFFF_FFC0) | wdata;
            set_config(first, last, wdata);
            no_gaps = (phase == 2);
            n = $urandom_range(18, 30);
            for (j = 0; j < n; j++) begin
                if (phase % 3 == 1 && j == n / 2) begin
                    write_one(swnd_pkg::REG_WINDOW_SIZE, $urandom_range(0, 63));
                end
                w = active_slots();
                r = $urandom_range(0, 99);
                ack = $urandom();
                cmd = swnd_pkg::CMD_ACK;
                if (!pred_active && r < 85) begin
                    cmd = swnd_pkg::CMD_START;
                end else if (r < 50) begin
                    ack = pred_base + $urandom_range(1, w);
                end else if (r < 62) begin
                    cmd = swnd_pkg::CMD_TIMEOUT;
                end else if (r < 70) begin
                    ack = pred_base;
                end else if (r < 75) begin
                    ack = pred_last_seq + 1 + $urandom_range(0, 3);
                end else if (r < 83) begin
                    // fully random ack already drawn
                end else if (r < 88) begin
                    cmd = CMD_RESERVED;
                end else if (r < 93) begin
                    ack = pred_base - $urandom_range(1, 5);
                end else begin
                    cmd = swnd_pkg::CMD_START;
                end
                if (cmd == swnd_pkg::CMD_START || (cmd != CMD_RESERVED && pred_active)) begin
                    counted++;
                end
                send_command(cmd, ack);
            end
            no_gaps = 1'b0;
            phase++;
        end
    endtask

    // Sequence of tests
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= swnd_pkg::CMD_START;
        s_ack_number <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= swnd_pkg::REG_FIRST_SEQ;
        cfg_data <= '0;
        pred_first_seq = '0;
        pred_last_seq = '0;
        pred_wsize = swnd_pkg::WINDOW_SIZE_RESET;
        pred_base = '0;
        pred_active = 1'b0;
        pred_sent = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_window_slide();
        test_sequence_limits();
        test_window_resize();
        test_random_traffic();

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
